// ===== design/aabb_pkg.sv =====
// Package for the trigger-box block: field types, kind and result codes,
// default table sizes and a result builder. Depends on nothing.
package aabb_pkg;

   localparam int MAX_BOXES_DEF  = 16;
   localparam int MAX_BODIES_DEF = 16;
   localparam int MAX_EVENTS     = 16;
   localparam int EVW            = $clog2(MAX_EVENTS + 1);

   // Input kinds.
   localparam logic [2:0] K_ADD     = 3'd0;
   localparam logic [2:0] K_REMOVE  = 3'd1;
   localparam logic [2:0] K_TRACK   = 3'd2;
   localparam logic [2:0] K_UNTRACK = 3'd3;
   localparam logic [2:0] K_POS     = 3'd4;
   localparam logic [2:0] K_QUERY   = 3'd5;

   // Result kinds.
   localparam logic [2:0] RK_ADDED     = 3'd0;
   localparam logic [2:0] RK_BOX_FULL  = 3'd1;
   localparam logic [2:0] RK_DONE      = 3'd2;
   localparam logic [2:0] RK_BODY_FULL = 3'd3;
   localparam logic [2:0] RK_ENTERED   = 3'd4;
   localparam logic [2:0] RK_EXITED    = 3'd5;
   localparam logic [2:0] RK_ANSWER    = 3'd6;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        body_id;
      logic [3:0]         volume_index;
      logic [31:0]        tag;
      logic signed [31:0] corner_a_x;
      logic signed [31:0] corner_a_y;
      logic signed [31:0] corner_a_z;
      logic signed [31:0] corner_b_x;
      logic signed [31:0] corner_b_y;
      logic signed [31:0] corner_b_z;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [3:0]  out_volume_index;
      logic [31:0] out_tag;
      logic [31:0] out_body_id;
      logic        inside_res;
      logic        last;
   } rsp_type;

   // One stored box: corners and tag.
   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
      logic [31:0]        tag;
   } box_type;

   function automatic rsp_type mk_res(input logic [2:0] kind, input logic [3:0] idx,
                                      input logic [31:0] tag, input logic [31:0] body,
                                      input logic in_box);
      rsp_type r;
      r.result_kind      = kind;
      r.out_volume_index = idx;
      r.out_tag          = tag;
      r.out_body_id      = body;
      r.inside_res       = in_box;
      r.last             = 1'b0;
      return r;
   endfunction

endpackage

// ===== design/aabb_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on aabb_pkg for the payload types.
interface aabb_req_if;
   logic                 valid;
   logic                 ready;
   aabb_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface aabb_rsp_if;
   logic                 valid;
   logic                 ready;
   aabb_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/aabb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module aabb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/aabb_trigger_enter_exit.sv =====
// Top level of the trigger-box block: box and body tables in RAM, scan sequencer.
// Depends on aabb_pkg, aabb_if and aabb_ram.
//
//   channel | direction | beat carries
//   --------+-----------+-------------------------------------------------
//   req_bus | in        | one command: add/remove box, track/untrack, position, query
//   rsp_bus | out       | one result; last marks the final beat of a command
//
// Add, remove and unused kinds go from idle straight to the send state. Track,
// untrack, query and position commands scan the body-identifier RAM one entry per
// cycle. A position sample then scans the stored boxes one per cycle while the
// result channel does not stall it. Reset clears the box count, the active
// and body-valid marks and the sequencer; no RAM clearing pass is needed. A stalled
// result channel holds the box scan in place; a new command is taken once the final
// beat of the previous one sits in the output register.
module aabb_trigger_enter_exit #(
   parameter int MAX_BOXES  = aabb_pkg::MAX_BOXES_DEF,
   parameter int MAX_BODIES = aabb_pkg::MAX_BODIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   aabb_req_if.sink    req_bus,
   aabb_rsp_if.source  rsp_bus
);
   import aabb_pkg::*;

   localparam int BXW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int BDW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CW  = $clog2(MAX_BOXES + 1);
   localparam int BOXW = $bits(box_type);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1;
   localparam logic [2:0] S_QRD   = 3'd2;
   localparam logic [2:0] S_PLOAD = 3'd3;
   localparam logic [2:0] S_PSCAN = 3'd4;
   localparam logic [2:0] S_PEND  = 3'd5;
   localparam logic [2:0] S_SEND  = 3'd6;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [CW-1:0]         box_count_ff, box_count_in;
   logic [MAX_BOXES-1:0]  active_ff, active_in;
   logic [MAX_BODIES-1:0] body_valid_ff, body_valid_in;
   logic [BDW-1:0]        chk_ff, chk_in;
   logic                  free_found_ff, free_found_in;
   logic [BDW-1:0]        free_idx_ff, free_idx_in;
   logic [BDW-1:0]        bidx_ff, bidx_in;
   logic [BXW-1:0]        i_ff, i_in;
   logic [EVW-1:0]        ev_cnt_ff, ev_cnt_in;
   logic [MAX_BOXES-1:0]  row_ff, row_in;
   rsp_type               stage_ff, stage_in;
   logic                  pend_v_ff, pend_v_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic                  box_we;
   logic [BXW-1:0]        box_waddr, box_raddr;
   box_type               box_wdata, box_rdata;
   logic                  id_we;
   logic [BDW-1:0]        id_waddr, id_raddr;
   logic [31:0]           id_rdata;
   logic                  in_we;
   logic [BDW-1:0]        in_waddr, in_raddr;
   logic [MAX_BOXES-1:0]  in_wdata, in_rdata;

   logic                  req_ready_w;
   logic                  accept;
   logic                  out_free;
   logic                  load_out;
   rsp_type               out_data;
   logic                  hit, free_here, free_any, last_chk;
   logic [BDW-1:0]        free_sel;
   logic                  vi_ok;
   logic [MAX_BOXES-1:0]  q_shift;
   logic                  now_in, chg, is_last_box, stall;

   assign req_ready_w     = (state_ff == S_IDLE);
   assign req_bus.ready   = req_ready_w;
   assign accept          = req_bus.valid && req_ready_w;
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   // Body lookup: the identifier read issued last cycle belongs to chk_ff.
   assign hit       = body_valid_ff[chk_ff] && (id_rdata == req_ff.body_id);
   assign free_here = !body_valid_ff[chk_ff];
   assign free_any  = free_found_ff || free_here;
   assign free_sel  = free_found_ff ? free_idx_ff : chk_ff;
   assign last_chk  = (chk_ff == BDW'(MAX_BODIES - 1));

   // A box index is usable only below the current box count.
   assign vi_ok   = ({{CW{1'b0}}, req_ff.volume_index} < {4'b0000, box_count_ff});
   assign q_shift = in_rdata >> req_ff.volume_index;

   // Containment test against the box read for index i_ff; faces count as inside.
   assign now_in = active_ff[i_ff] &&
                   (req_ff.corner_a_x >= box_rdata.min_x) &&
                   (req_ff.corner_a_x <= box_rdata.max_x) &&
                   (req_ff.corner_a_y >= box_rdata.min_y) &&
                   (req_ff.corner_a_y <= box_rdata.max_y) &&
                   (req_ff.corner_a_z >= box_rdata.min_z) &&
                   (req_ff.corner_a_z <= box_rdata.max_z);
   assign chg         = (now_in != row_ff[i_ff]);
   assign is_last_box = ((CW'(i_ff) + CW'(1)) == box_count_ff);
   // A second change cannot be taken while the pending event still cannot leave.
   assign stall       = (state_ff == S_PSCAN) && chg && pend_v_ff && !out_free &&
                        (ev_cnt_ff != EVW'(MAX_EVENTS));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      box_count_in  = box_count_ff;
      active_in     = active_ff;
      body_valid_in = body_valid_ff;
      chk_in        = chk_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      bidx_in       = bidx_ff;
      i_in          = i_ff;
      ev_cnt_in     = ev_cnt_ff;
      row_in        = row_ff;
      stage_in      = stage_ff;
      pend_v_in     = pend_v_ff;
      load_out      = 1'b0;
      out_data      = stage_ff;

      box_we        = 1'b0;
      box_waddr     = box_count_ff[BXW-1:0];
      box_wdata.min_x = req_bus.payload.corner_a_x;
      box_wdata.min_y = req_bus.payload.corner_a_y;
      box_wdata.min_z = req_bus.payload.corner_a_z;
      box_wdata.max_x = req_bus.payload.corner_b_x;
      box_wdata.max_y = req_bus.payload.corner_b_y;
      box_wdata.max_z = req_bus.payload.corner_b_z;
      box_wdata.tag   = req_bus.payload.tag;
      box_raddr     = stall ? i_ff : BXW'(i_ff + 1'b1);
      id_we         = 1'b0;
      id_waddr      = free_sel;
      id_raddr      = BDW'(chk_ff + 1'b1);
      in_we         = 1'b0;
      in_waddr      = bidx_ff;
      in_wdata      = row_ff;
      in_raddr      = chk_ff;

      case (state_ff)
         S_IDLE: begin
            id_raddr = '0;
            if (accept) begin
               req_in        = req_bus.payload;
               chk_in        = '0;
               free_found_in = 1'b0;
               state_in      = S_SEND;
               stage_in      = mk_res(RK_DONE, 4'd0, 32'd0, 32'd0, 1'b0);
               case (req_bus.payload.kind)
                  K_ADD: begin
                     if (box_count_ff < CW'(MAX_BOXES)) begin
                        box_we       = 1'b1;
                        active_in[box_count_ff[BXW-1:0]] = 1'b1;
                        box_count_in = box_count_ff + 1'b1;
                        stage_in     = mk_res(RK_ADDED, 4'(box_count_ff), 32'd0,
                                              32'd0, 1'b0);
                     end else begin
                        stage_in = mk_res(RK_BOX_FULL, 4'd0, 32'd0, 32'd0, 1'b0);
                     end
                  end
                  K_REMOVE: begin
                     if ({{CW{1'b0}}, req_bus.payload.volume_index} <
                         {4'b0000, box_count_ff}) begin
                        active_in[BXW'(req_bus.payload.volume_index)] = 1'b0;
                     end
                  end
                  K_TRACK, K_UNTRACK, K_POS, K_QUERY: begin
                     state_in = S_FIND;
                  end
                  default: begin
                     state_in = S_SEND;
                  end
               endcase
            end
         end

         S_FIND: begin
            if (free_here && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_ff;
            end
            if (hit || last_chk) begin
               bidx_in  = chk_ff;
               state_in = S_SEND;
               stage_in = mk_res(RK_DONE, 4'd0, 32'd0, 32'd0, 1'b0);
               case (req_ff.kind)
                  K_TRACK: begin
                     if (!hit) begin
                        if (free_any) begin
                           body_valid_in[free_sel] = 1'b1;
                           id_we    = 1'b1;
                           in_we    = 1'b1;
                           in_waddr = free_sel;
                           in_wdata = '0;
                        end else begin
                           stage_in = mk_res(RK_BODY_FULL, 4'd0, 32'd0, 32'd0, 1'b0);
                        end
                     end
                  end
                  K_UNTRACK: begin
                     if (hit) begin
                        body_valid_in[chk_ff] = 1'b0;
                     end
                  end
                  K_QUERY: begin
                     if (hit) begin
                        state_in = S_QRD;
                     end else begin
                        stage_in = mk_res(RK_ANSWER, 4'd0, 32'd0, req_ff.body_id, 1'b0);
                     end
                  end
                  K_POS: begin
                     if (hit) begin
                        state_in = S_PLOAD;
                     end
                  end
                  default: begin
                     state_in = S_SEND;
                  end
               endcase
            end else begin
               chk_in = BDW'(chk_ff + 1'b1);
            end
         end

         S_QRD: begin
            stage_in = mk_res(RK_ANSWER, 4'd0, 32'd0, req_ff.body_id,
                              vi_ok && q_shift[0]);
            state_in = S_SEND;
         end

         S_PLOAD: begin
            row_in    = in_rdata;
            i_in      = '0;
            ev_cnt_in = '0;
            pend_v_in = 1'b0;
            box_raddr = '0;
            state_in  = (box_count_ff == '0) ? S_PEND : S_PSCAN;
         end

         S_PSCAN: begin
            if (chg && (ev_cnt_ff == EVW'(MAX_EVENTS))) begin
               // Event limit reached: this box keeps its old bit.
               state_in = S_PEND;
            end else if (!stall) begin
               if (chg) begin
                  if (pend_v_ff) begin
                     load_out      = 1'b1;
                     out_data      = stage_ff;
                     out_data.last = 1'b0;
                  end
                  stage_in = mk_res(now_in ? RK_ENTERED : RK_EXITED, 4'(i_ff),
                                    box_rdata.tag, req_ff.body_id, 1'b0);
                  pend_v_in      = 1'b1;
                  row_in[i_ff]   = now_in;
                  ev_cnt_in      = ev_cnt_ff + 1'b1;
               end
               if (is_last_box) begin
                  state_in = S_PEND;
               end else begin
                  i_in = BXW'(i_ff + 1'b1);
               end
            end
         end

         S_PEND: begin
            in_we = 1'b1;
            if (!pend_v_ff) begin
               stage_in = mk_res(RK_DONE, 4'd0, 32'd0, 32'd0, 1'b0);
            end
            state_in = S_SEND;
         end

         S_SEND: begin
            if (out_free) begin
               load_out      = 1'b1;
               out_data      = stage_ff;
               out_data.last = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = load_out ? out_data : rsp_data_ff;
      rsp_valid_in = load_out ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         box_count_ff  <= '0;
         active_ff     <= '0;
         body_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         box_count_ff  <= box_count_in;
         active_ff     <= active_in;
         body_valid_ff <= body_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_v_ff     <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      chk_ff        <= chk_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      bidx_ff       <= bidx_in;
      i_ff          <= i_in;
      ev_cnt_ff     <= ev_cnt_in;
      row_ff        <= row_in;
      stage_ff      <= stage_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Box corners and tags.
   aabb_ram #(.WIDTH(BOXW), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock   (clock),
      .wr_en   (box_we),
      .wr_addr (box_waddr),
      .wr_data (box_wdata),
      .rd_addr (box_raddr),
      .rd_data (box_rdata)
   );

   // Body identifiers.
   aabb_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (req_ff.body_id),
      .rd_addr (id_raddr),
      .rd_data (id_rdata)
   );

   // Inside bits, one row of MAX_BOXES bits per body slot.
   aabb_ram #(.WIDTH(MAX_BOXES), .DEPTH(MAX_BODIES)) u_inside_ram (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (in_waddr),
      .wr_data (in_wdata),
      .rd_addr (in_raddr),
      .rd_data (in_rdata)
   );

endmodule

// ===== design/aabb_checker.sv =====
// Port-level checker for the trigger-box block, bound to the top level.
// Depends on the top level's channel ports only.
module aabb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   // A result beat waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Nothing is shown right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

   // While a command still has beats to come, no new command is taken.
   a_no_take_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command taken before final beat");

   // In the cycle after a command is taken, the block is not ready.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a command");
endmodule

bind aabb_trigger_enter_exit aabb_checker u_aabb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_last  (rsp_bus.payload.last)
);

// ===== tb/tb.sv =====
// Self-checking bench for the trigger-box block: directed table, table-full runs and random traffic.
// Depends on aabb_pkg, aabb_if and the block's top level.
module tb;
   import aabb_pkg::*;

   localparam int NBOX  = MAX_BOXES_DEF;
   localparam int NBODY = MAX_BODIES_DEF;
   localparam int N_RANDOM = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aabb_req_if req_bus ();
   aabb_rsp_if rsp_bus ();

   aabb_trigger_enter_exit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the box and body tables; the table entries keep the block's own widths.
   int unsigned        shadow_box_count;
   box_type            shadow_box [NBOX];
   logic [NBOX-1:0]    shadow_box_live;
   logic [31:0]        shadow_body_id [NBODY];
   logic [NBODY-1:0]   shadow_body_live;
   logic [NBOX-1:0]    shadow_inside [NBODY];

   rsp_type pending_results [$];
   int      fail_count = 0;
   int      results_seen = 0;
   bit      long_hold = 1'b0;
   bit      stim_done = 1'b0;

   // Directed rows: a command, plus an expected last result where it is obvious.
   typedef struct {
      req_type cmd;
      bit      has_fixed;
      rsp_type fixed;
   } stim_row;
   stim_row directed_rows [$];

   function automatic int lookup_body(input logic [31:0] id);
      for (int i = 0; i < NBODY; i++)
         if (shadow_body_live[i] && shadow_body_id[i] == id) return i;
      return -1;
   endfunction

   function automatic bit point_in_box(input box_type bx, input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       input logic signed [31:0] z);
      // A point lying on a face counts as inside.
      return x >= bx.min_x && x <= bx.max_x && y >= bx.min_y && y <= bx.max_y &&
             z >= bx.min_z && z <= bx.max_z;
   endfunction

   function automatic rsp_type make_result(input logic [2:0] kind, input logic [3:0] idx,
                                           input logic [31:0] tag, input logic [31:0] body,
                                           input logic in_box);
      rsp_type r;
      r.result_kind      = kind;
      r.out_volume_index = idx;
      r.out_tag          = tag;
      r.out_body_id      = body;
      r.inside_res       = in_box;
      r.last             = 1'b0;
      return r;
   endfunction

   // Predicts the results of one accepted command and updates the shadow tables.
   task automatic predict_trigger_results(input req_type c);
      rsp_type out_list [$];
      int      slot;
      bit      now_in;
      box_type bx;
      case (c.kind)
         K_ADD: begin
            if (shadow_box_count < NBOX) begin
               bx.min_x = c.corner_a_x; bx.min_y = c.corner_a_y; bx.min_z = c.corner_a_z;
               bx.max_x = c.corner_b_x; bx.max_y = c.corner_b_y; bx.max_z = c.corner_b_z;
               bx.tag   = c.tag;
               shadow_box[shadow_box_count] = bx;
               shadow_box_live[shadow_box_count] = 1'b1;
               for (int b = 0; b < NBODY; b++) shadow_inside[b][shadow_box_count] = 1'b0;
               out_list = {out_list,
                           make_result(RK_ADDED, shadow_box_count[3:0], 0, 0, 0)};
               shadow_box_count++;
            end else begin
               out_list = {out_list, make_result(RK_BOX_FULL, 0, 0, 0, 0)};
            end
         end
         K_REMOVE: begin
            if (c.volume_index < shadow_box_count) shadow_box_live[c.volume_index] = 1'b0;
            out_list = {out_list, make_result(RK_DONE, 0, 0, 0, 0)};
         end
         K_TRACK: begin
            if (lookup_body(c.body_id) >= 0) begin
               out_list = {out_list, make_result(RK_DONE, 0, 0, 0, 0)};
            end else begin
               slot = -1;
               for (int b = NBODY - 1; b >= 0; b--) if (!shadow_body_live[b]) slot = b;
               if (slot >= 0) begin
                  shadow_body_live[slot] = 1'b1;
                  shadow_body_id[slot]   = c.body_id;
                  shadow_inside[slot]    = '0;
                  out_list = {out_list, make_result(RK_DONE, 0, 0, 0, 0)};
               end else begin
                  out_list = {out_list, make_result(RK_BODY_FULL, 0, 0, 0, 0)};
               end
            end
         end
         K_UNTRACK: begin
            slot = lookup_body(c.body_id);
            if (slot >= 0) shadow_body_live[slot] = 1'b0;
            out_list = {out_list, make_result(RK_DONE, 0, 0, 0, 0)};
         end
         K_POS: begin
            slot = lookup_body(c.body_id);
            if (slot >= 0) begin
               for (int i = 0; i < shadow_box_count; i++) begin
                  now_in = shadow_box_live[i] &&
                           point_in_box(shadow_box[i], c.corner_a_x, c.corner_a_y,
                                        c.corner_a_z);
                  if (now_in != shadow_inside[slot][i]) begin
                     out_list = {out_list, make_result(now_in ? RK_ENTERED : RK_EXITED,
                                                       i[3:0], shadow_box[i].tag,
                                                       c.body_id, 0)};
                     shadow_inside[slot][i] = now_in;
                  end
               end
            end
            if (out_list.size() == 0)
               out_list = {out_list, make_result(RK_DONE, 0, 0, 0, 0)};
         end
         K_QUERY: begin
            slot = lookup_body(c.body_id);
            out_list = {out_list, make_result(RK_ANSWER, 0, 0, c.body_id,
               (slot >= 0 && c.volume_index < shadow_box_count) ?
               shadow_inside[slot][c.volume_index] : 1'b0)};
         end
         default: out_list = {out_list, make_result(RK_DONE, 0, 0, 0, 0)};
      endcase
      out_list[out_list.size() - 1].last = 1'b1;
      pending_results = {pending_results, out_list};
   endtask

   function automatic req_type blank_cmd(input logic [2:0] kind);
      req_type c;
      c = '0;
      c.kind = kind;
      return c;
   endfunction

   function automatic req_type box_cmd(input logic signed [31:0] lo,
                                       input logic signed [31:0] hi,
                                       input logic [31:0] tag);
      req_type c;
      c = blank_cmd(K_ADD);
      c.corner_a_x = lo; c.corner_a_y = lo; c.corner_a_z = lo;
      c.corner_b_x = hi; c.corner_b_y = hi; c.corner_b_z = hi;
      c.tag = tag;
      return c;
   endfunction

   function automatic req_type body_cmd(input logic [2:0] kind, input logic [31:0] id,
                                        input logic signed [31:0] p,
                                        input logic [3:0] vi);
      req_type c;
      c = blank_cmd(kind);
      c.body_id = id;
      c.corner_a_x = p; c.corner_a_y = p; c.corner_a_z = p;
      c.volume_index = vi;
      return c;
   endfunction

   task automatic add_row(input req_type c, input bit has_fixed, input rsp_type r);
      stim_row row;
      row.cmd = c;
      row.has_fixed = has_fixed;
      row.fixed = r;
      directed_rows = {directed_rows, row};
   endtask

   // Random command: mostly a coherent mix on a small pool of bodies and points near
   // the boxes, with some noise across whole field ranges.
   function automatic req_type random_cmd();
      req_type c;
      int      pick;
      logic [31:0] ids [4] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678};
      c = '0;
      c.tag          = $urandom;
      c.volume_index = $urandom_range(0, 15);
      c.body_id      = ($urandom_range(0, 9) == 0) ? $urandom : ids[$urandom_range(0, 3)];
      pick = $urandom_range(0, 99);
      if (pick < 8) c.kind = K_ADD;
      else if (pick < 14) c.kind = K_REMOVE;
      else if (pick < 24) c.kind = K_TRACK;
      else if (pick < 29) c.kind = K_UNTRACK;
      else if (pick < 80) c.kind = K_POS;
      else if (pick < 96) c.kind = K_QUERY;
      else c.kind = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 4) == 0) begin
         c.corner_a_x = $urandom; c.corner_a_y = $urandom; c.corner_a_z = $urandom;
         c.corner_b_x = $urandom; c.corner_b_y = $urandom; c.corner_b_z = $urandom;
      end else begin
         c.corner_a_x = $signed($urandom_range(0, 400)) - 200;
         c.corner_a_y = $signed($urandom_range(0, 400)) - 200;
         c.corner_a_z = $signed($urandom_range(0, 400)) - 200;
         c.corner_b_x = c.corner_a_x + $signed($urandom_range(0, 200));
         c.corner_b_y = c.corner_a_y + $signed($urandom_range(0, 200));
         c.corner_b_z = c.corner_a_z + $signed($urandom_range(0, 200));
      end
      return c;
   endfunction

   // Sends one command, with a random gap ahead of it unless bursty, then predicts its results.
   task automatic send_cmd(input req_type c, input bit bursty);
      int gap;
      gap = bursty ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_trigger_results(c);
   endtask

   // Stimulus.
   initial begin
      stim_row row;
      int      burst;
      rsp_type none;
      none = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      shadow_box_count = 0;
      shadow_box_live  = '0;
      shadow_body_live = '0;
      for (int i = 0; i < NBOX; i++) shadow_box[i] = '0;
      for (int i = 0; i < NBODY; i++) begin
         shadow_body_id[i] = '0;
         shadow_inside[i]  = '0;
      end

      // Right after reset: full-range untracked body, empty tables, unused kinds.
      add_row(body_cmd(K_QUERY, 32'hFFFF_FFFF, 0, 4'hF), 1,
              '{RK_ANSWER, 4'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1});
      add_row(body_cmd(K_POS, 32'h0, 0, 0), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      add_row(body_cmd(K_UNTRACK, 32'h5, 0, 0), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      add_row(body_cmd(K_REMOVE, 0, 0, 4'hF), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      add_row(blank_cmd(3'd6), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      add_row(blank_cmd(3'd7), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      // Full-range box, a unit box and an inverted box that holds no point.
      add_row(box_cmd(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF), 1,
              '{RK_ADDED, 0, 0, 0, 0, 1});
      add_row(box_cmd(-32'sh0001_0000, 32'sh0001_0000, 32'hA5A5_5A5A), 1,
              '{RK_ADDED, 1, 0, 0, 0, 1});
      add_row(box_cmd(32'sh0001_0000, -32'sh0001_0000, 32'h0000_0001), 1,
              '{RK_ADDED, 2, 0, 0, 0, 1});
      add_row(body_cmd(K_TRACK, 32'hFFFF_FFFF, 0, 0), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      add_row(body_cmd(K_TRACK, 32'hFFFF_FFFF, 0, 0), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      add_row(body_cmd(K_TRACK, 32'h0, 0, 0), 1, '{RK_DONE, 0, 0, 0, 0, 1});
      // On a face of the unit box, then at the extremes, then out again.
      add_row(body_cmd(K_POS, 32'hFFFF_FFFF, 32'sh0001_0000, 0), 0, none);
      add_row(body_cmd(K_QUERY, 32'hFFFF_FFFF, 0, 4'h1), 0, none);
      add_row(body_cmd(K_POS, 32'hFFFF_FFFF, 32'sh8000_0000, 0), 0, none);
      add_row(body_cmd(K_POS, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0), 0, none);
      add_row(body_cmd(K_POS, 32'h0, 0, 0), 0, none);
      // Removing a box inside which a body sits yields an exit on the next sample.
      add_row(body_cmd(K_REMOVE, 0, 0, 4'h1), 0, none);
      add_row(body_cmd(K_POS, 32'h0, 0, 0), 0, none);
      add_row(body_cmd(K_UNTRACK, 32'h0, 0, 0), 0, none);
      add_row(body_cmd(K_QUERY, 32'h0, 0, 4'h0), 0, none);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (directed_rows.size() > 0) begin
         row = directed_rows.pop_front();
         send_cmd(row.cmd, 1'($urandom_range(0, 1)));
         if (row.has_fixed && pending_results[$] != row.fixed) begin
            $display("%0t directed row mismatch: expected %p actual prediction %p",
                     $time, row.fixed, pending_results[$]);
            fail_count++;
         end
      end

      // Fill the body table until it reports full, so that the full result shows up.
      for (int i = 0; i < NBODY + 1; i++)
         send_cmd(body_cmd(K_TRACK, 32'h100 + i, 0, 0), 1);
      for (int i = 0; i < NBODY + 1; i++)
         send_cmd(body_cmd(K_UNTRACK, 32'h100 + i, 0, 0), 1);

      // Random part, in bursts of back-to-back beats separated by gaps.
      burst = 0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 60) long_hold = 1'b1;
         if (burst == 0) burst = $urandom_range(1, 8);
         send_cmd(random_cmd(), burst != 1);
         burst--;
      end
      // Box table full: keep adding until it must report so.
      for (int i = 0; i < NBOX + 1; i++)
         send_cmd(box_cmd(-32'sd10, 32'sd10, $urandom), 1);
      for (int n = 0; n < 20; n++) send_cmd(random_cmd(), 0);
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Result side: stalls on its own pattern, with one long hold-off while commands
   // keep coming, so the block backs up and stalls its input channel.
   initial begin
      int phase;
      rsp_bus.ready = 1'b0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         phase++;
         if ((phase / 64) % 3 == 2) rsp_bus.ready <= 1'b1;
         else rsp_bus.ready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
      end
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result beat: actual %p", $time, rsp_bus.payload);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.payload.result_kind !== want.result_kind) begin
               $display("%0t result_kind: expected %0d actual %0d", $time,
                        want.result_kind, rsp_bus.payload.result_kind);
               fail_count++;
            end
            if (rsp_bus.payload.out_volume_index !== want.out_volume_index) begin
               $display("%0t out_volume_index: expected %0d actual %0d", $time,
                        want.out_volume_index, rsp_bus.payload.out_volume_index);
               fail_count++;
            end
            if (rsp_bus.payload.out_tag !== want.out_tag) begin
               $display("%0t out_tag: expected %h actual %h", $time,
                        want.out_tag, rsp_bus.payload.out_tag);
               fail_count++;
            end
            if (rsp_bus.payload.out_body_id !== want.out_body_id) begin
               $display("%0t out_body_id: expected %h actual %h", $time,
                        want.out_body_id, rsp_bus.payload.out_body_id);
               fail_count++;
            end
            if (rsp_bus.payload.inside_res !== want.inside_res) begin
               $display("%0t inside_res: expected %b actual %b", $time,
                        want.inside_res, rsp_bus.payload.inside_res);
               fail_count++;
            end
            if (rsp_bus.payload.last !== want.last) begin
               $display("%0t last: expected %b actual %b", $time,
                        want.last, rsp_bus.payload.last);
               fail_count++;
            end
         end
      end
   end

   // End of run: drain, allow a few extra cycles for stray beats, then report.
   initial begin
      wait (stim_done);
      while (pending_results.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("PASS aabb_trigger_enter_exit");
      else
         $display("FAIL aabb_trigger_enter_exit");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("FAIL aabb_trigger_enter_exit");
      $finish;
   end
endmodule

// ===== files.f =====
design/aabb_pkg.sv
design/aabb_if.sv
design/aabb_ram.sv
design/aabb_trigger_enter_exit.sv
design/aabb_checker.sv
tb/tb.sv
